### src/mrme_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mrme_pkg;

  localparam int MAX_VERTICES_DEF = 64;
  localparam int DIST_BITS_DEF    = 32;

  localparam int KIND_W   = 2;
  localparam int VERTEX_W = 6;
  localparam int DIST_W   = 32;
  localparam int SUM_W    = 48;

  localparam logic [SUM_W-1:0] SUM_LIMIT = {SUM_W{1'b1}};

  typedef enum logic [KIND_W-1:0] {
    KIND_PAIR  = 2'd0,
    KIND_DEPOT = 2'd1,
    KIND_VISIT = 2'd2
  } kind_t;

  typedef struct packed {
    logic pair_we;
    logic depot_we;
    logic rd_en;
  } store_ctl_t;

endpackage

`default_nettype wire

### src/mrme_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface mrme_in_if;
  logic                          valid;
  logic                          ready;
  logic [mrme_pkg::KIND_W-1:0]   kind;
  logic [mrme_pkg::VERTEX_W-1:0] vertex;
  logic [mrme_pkg::VERTEX_W-1:0] other_vertex;
  logic [mrme_pkg::DIST_W-1:0]   distance;
  logic                          route_end;
  logic                          solution_end;

  modport source (
    output valid, kind, vertex, other_vertex, distance, route_end, solution_end,
    input  ready
  );
  modport sink (
    input  valid, kind, vertex, other_vertex, distance, route_end, solution_end,
    output ready
  );
endinterface

interface mrme_out_if;
  logic                       valid;
  logic                       ready;
  logic [mrme_pkg::SUM_W-1:0] max_route_length;
  logic                       saturated;

  modport source (
    output valid, max_route_length, saturated,
    input  ready
  );
  modport sink (
    input  valid, max_route_length, saturated,
    output ready
  );
endinterface

`default_nettype wire

### src/mrme_dist_store.sv
`timescale 1ns / 1ps
`default_nettype none

module mrme_dist_store #(
  parameter int VAW       = 6,
  parameter int DIST_BITS = 32
) (
  input  logic                  clk,
  input  mrme_pkg::store_ctl_t  ctl,
  input  logic [2*VAW-1:0]      pair_waddr,
  input  logic [2*VAW-1:0]      pair_raddr,
  input  logic [VAW-1:0]        depot_addr,
  input  logic [DIST_BITS-1:0]  wdata,
  output logic [DIST_BITS-1:0]  rd_pair,
  output logic [DIST_BITS-1:0]  rd_depot
);
  import mrme_pkg::*;

  localparam int PAIR_DEPTH  = 1 << (2 * VAW);
  localparam int DEPOT_DEPTH = 1 << VAW;

  // pair table keeps one copy per unordered pair, addressed {low, high}
  logic [DIST_BITS-1:0] pair_mem  [PAIR_DEPTH];
  logic [DIST_BITS-1:0] depot_mem [DEPOT_DEPTH];
  logic [DIST_BITS-1:0] rd_pair_r;
  logic [DIST_BITS-1:0] rd_depot_r;

  always_ff @(posedge clk) begin
    if (ctl.pair_we) begin
      pair_mem[pair_waddr] <= wdata;
    end
    if (ctl.rd_en) begin
      rd_pair_r <= pair_mem[pair_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.depot_we) begin
      depot_mem[depot_addr] <= wdata;
    end
    if (ctl.rd_en) begin
      rd_depot_r <= depot_mem[depot_addr];
    end
  end

  assign rd_pair  = rd_pair_r;
  assign rd_depot = rd_depot_r;

endmodule

`default_nettype wire

### src/multi_route_max_length_evaluator_core.sv
// Longest-route evaluator for multi-route tour candidates.
// in_ch carries three kinds of transfer: a pair distance write, a depot
// distance write, and a visit of one vertex with route_end / solution_end
// flags. Table writes take effect for any later visit. out_ch carries one
// transfer per visit with solution_end set: the longest route length of
// the candidate, saturated at 2^48-1, and a flag if any route saturated.
// Throughput: one input transfer per cycle while in_ch.ready is high. Visits
// run through a four stage pipeline (table read, step add, depot return add,
// max fold), each stage registered; the max fold writes the output register.
// The loop that bounds the rate is the running route sum register, one
// 48-bit saturating add per cycle.
// Reset clears the pipeline, the route state and the running maximum. The
// distance tables are not cleared and must be written before they are
// read. When out_ch stalls, input transfers continue until a second result
// reaches the last stage; in_ch.ready then drops until out_ch drains.
`timescale 1ns / 1ps
`default_nettype none

module multi_route_max_length_evaluator_core #(
  parameter int MAX_VERTICES = mrme_pkg::MAX_VERTICES_DEF,
  parameter int DIST_BITS    = mrme_pkg::DIST_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  mrme_in_if.sink     in_ch,
  mrme_out_if.source  out_ch
);
  import mrme_pkg::*;

  localparam int VAW   = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int EXT_W = VAW + VERTEX_W;

  logic stall, adv, acc, is_visit, end_any;

  logic [EXT_W-1:0] v_ext, o_ext, p_ext;
  logic [VAW-1:0]   v_idx, o_idx, p_idx;
  logic             v_ok, o_ok, p_ok;
  logic [VAW-1:0]   w_lo, w_hi, r_lo, r_hi;

  logic [DIST_BITS+DIST_W-1:0] d_ext;
  logic [DIST_BITS-1:0]        wdata;
  store_ctl_t                  ctl;
  logic [DIST_BITS-1:0]        rd_pair, rd_depot;

  logic [VERTEX_W-1:0] prev_r, prev_nxt;
  logic                open_r, open_nxt;

  logic s1_vld_r, s1_start_r, s1_end_r, s1_sol_r, s1_pok_r, s1_dok_r;

  logic [SUM_W+DIST_BITS-1:0] pair_ext, depot_ext;
  logic [SUM_W-1:0]           pair_x, depot_x;
  logic [SUM_W:0]             step_add;
  logic [SUM_W-1:0]           s2_sum_nxt;
  logic                       s2_ovf_nxt;

  logic             s2_vld_r, s2_end_r, s2_sol_r, s2_ovf_r;
  logic [SUM_W-1:0] s2_sum_r, s2_depot_r;

  logic [SUM_W:0]   close_add;
  logic [SUM_W-1:0] s3_len_nxt;
  logic             s3_ovf_nxt;

  logic             s3_vld_r, s3_end_r, s3_sol_r, s3_ovf_r;
  logic [SUM_W-1:0] s3_len_r;

  logic [SUM_W-1:0] cand, longest_r, longest_nxt;
  logic             ovf_acc_r, ovf_acc_nxt;
  logic             out_vld_r, out_vld_nxt, emit;
  logic [SUM_W-1:0] out_len_r;
  logic             out_sat_r;

  // intake
  assign stall       = s3_vld_r && s3_sol_r && out_vld_r && !out_ch.ready;
  assign adv         = !stall;
  assign in_ch.ready = adv;
  assign acc         = in_ch.valid && adv;
  assign is_visit    = (in_ch.kind == KIND_VISIT);
  assign end_any     = in_ch.route_end || in_ch.solution_end;

  assign v_ext = {{VAW{1'b0}}, in_ch.vertex};
  assign o_ext = {{VAW{1'b0}}, in_ch.other_vertex};
  assign p_ext = {{VAW{1'b0}}, prev_r};
  assign v_idx = v_ext[VAW-1:0];
  assign o_idx = o_ext[VAW-1:0];
  assign p_idx = p_ext[VAW-1:0];
  assign v_ok  = v_ext < EXT_W'(MAX_VERTICES);
  assign o_ok  = o_ext < EXT_W'(MAX_VERTICES);
  assign p_ok  = p_ext < EXT_W'(MAX_VERTICES);

  assign w_lo = (v_idx < o_idx) ? v_idx : o_idx;
  assign w_hi = (v_idx < o_idx) ? o_idx : v_idx;
  assign r_lo = (p_idx < v_idx) ? p_idx : v_idx;
  assign r_hi = (p_idx < v_idx) ? v_idx : p_idx;

  assign d_ext = {{DIST_BITS{1'b0}}, in_ch.distance};
  assign wdata = d_ext[DIST_BITS-1:0];

  assign ctl.pair_we  = acc && (in_ch.kind == KIND_PAIR) && v_ok && o_ok;
  assign ctl.depot_we = acc && (in_ch.kind == KIND_DEPOT) && v_ok;
  assign ctl.rd_en    = acc && is_visit;

  mrme_dist_store #(
    .VAW       (VAW),
    .DIST_BITS (DIST_BITS)
  ) u_store (
    .clk        (clk),
    .ctl        (ctl),
    .pair_waddr ({w_lo, w_hi}),
    .pair_raddr ({r_lo, r_hi}),
    .depot_addr (v_idx),
    .wdata      (wdata),
    .rd_pair    (rd_pair),
    .rd_depot   (rd_depot)
  );

  always_comb begin
    prev_nxt = prev_r;
    open_nxt = open_r;
    if (ctl.rd_en) begin
      prev_nxt = in_ch.vertex;
      open_nxt = !end_any;
    end
  end

  // step add: start a route with the depot leg or add the pair leg
  assign pair_ext  = {{SUM_W{1'b0}}, (s1_pok_r ? rd_pair : {DIST_BITS{1'b0}})};
  assign depot_ext = {{SUM_W{1'b0}}, (s1_dok_r ? rd_depot : {DIST_BITS{1'b0}})};
  assign pair_x    = pair_ext[SUM_W-1:0];
  assign depot_x   = depot_ext[SUM_W-1:0];
  assign step_add  = {1'b0, s2_sum_r} + {1'b0, pair_x};

  always_comb begin
    if (s1_start_r) begin
      s2_sum_nxt = depot_x;
      s2_ovf_nxt = 1'b0;
    end else if (step_add[SUM_W]) begin
      s2_sum_nxt = SUM_LIMIT;
      s2_ovf_nxt = 1'b1;
    end else begin
      s2_sum_nxt = step_add[SUM_W-1:0];
      s2_ovf_nxt = 1'b0;
    end
  end

  // return leg to the depot
  assign close_add = {1'b0, s2_sum_r} + {1'b0, s2_depot_r};

  always_comb begin
    if (close_add[SUM_W]) begin
      s3_len_nxt = SUM_LIMIT;
      s3_ovf_nxt = s2_ovf_r || s2_end_r;
    end else begin
      s3_len_nxt = close_add[SUM_W-1:0];
      s3_ovf_nxt = s2_ovf_r;
    end
  end

  // fold into running maximum
  assign cand = (s3_end_r && (s3_len_r > longest_r)) ? s3_len_r : longest_r;
  assign emit = adv && s3_vld_r && s3_sol_r;

  always_comb begin
    longest_nxt = longest_r;
    ovf_acc_nxt = ovf_acc_r;
    if (adv && s3_vld_r) begin
      if (s3_sol_r) begin
        longest_nxt = '0;
        ovf_acc_nxt = 1'b0;
      end else begin
        longest_nxt = cand;
        ovf_acc_nxt = ovf_acc_r || s3_ovf_r;
      end
    end
    if (emit) begin
      out_vld_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_vld_nxt = 1'b0;
    end else begin
      out_vld_nxt = out_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r    <= '0;
      open_r    <= 1'b0;
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      s3_vld_r  <= 1'b0;
      longest_r <= '0;
      ovf_acc_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      prev_r    <= prev_nxt;
      open_r    <= open_nxt;
      longest_r <= longest_nxt;
      ovf_acc_r <= ovf_acc_nxt;
      out_vld_r <= out_vld_nxt;
      if (adv) begin
        s1_vld_r <= ctl.rd_en;
        s2_vld_r <= s1_vld_r;
        s3_vld_r <= s2_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      s1_start_r <= !open_r;
      s1_end_r   <= end_any;
      s1_sol_r   <= in_ch.solution_end;
      s1_pok_r   <= p_ok && v_ok;
      s1_dok_r   <= v_ok;
    end
    if (adv && s1_vld_r) begin
      s2_sum_r   <= s2_sum_nxt;
      s2_ovf_r   <= s2_ovf_nxt;
      s2_depot_r <= depot_x;
      s2_end_r   <= s1_end_r;
      s2_sol_r   <= s1_sol_r;
    end
    if (adv && s2_vld_r) begin
      s3_len_r <= s3_len_nxt;
      s3_ovf_r <= s3_ovf_nxt;
      s3_end_r <= s2_end_r;
      s3_sol_r <= s2_sol_r;
    end
    if (emit) begin
      out_len_r <= cand;
      out_sat_r <= ovf_acc_r || s3_ovf_r;
    end
  end

  assign out_ch.valid            = out_vld_r;
  assign out_ch.max_route_length = out_len_r;
  assign out_ch.saturated        = out_sat_r;

  a_stall_only_on_waiting_result: assert property (
    @(posedge clk) disable iff (!rst_n) !in_ch.ready |-> out_vld_r
  ) else $error("intake stalled without a waiting result");

  a_result_from_solution_end: assert property (
    @(posedge clk) disable iff (!rst_n) $rose(out_vld_r) |-> $past(s3_vld_r && s3_sol_r)
  ) else $error("result raised without a solution end");

  a_clear_after_emit: assert property (
    @(posedge clk) disable iff (!rst_n) emit |=> (longest_r == '0) && !ovf_acc_r
  ) else $error("running maximum not cleared after result");

  a_overflow_pins_sum: assert property (
    @(posedge clk) disable iff (!rst_n) (s2_vld_r && s2_ovf_r) |-> (s2_sum_r == SUM_LIMIT)
  ) else $error("overflow flag without saturated sum");

endmodule

`default_nettype wire
